/* sv/lpfs_pkg.sv */
package lpfs_pkg;

   localparam int BYTES_PER_PANEL = 32;
   localparam int DEF_PANELS_PER_CHAIN = 10;
   localparam int MAX_X = 79;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_SHIFT = 1'b1;

   localparam logic REG_CHAIN0 = 1'b0;
   localparam logic REG_CHAIN1 = 1'b1;

   localparam logic [2:0] CHAIN0_COLOR_RESET = 3'd4;
   localparam logic [2:0] CHAIN1_COLOR_RESET = 3'd7;

   // one masked bit write into the frame store
   typedef struct packed {
      logic       en;
      logic [2:0] bit_sel;
      logic       value;
   } lpfs_wr_type;

   // scan position fields that ride along with a shift read
   typedef struct packed {
      logic       chain;
      logic [2:0] bit_sel;
      logic [1:0] row;
      logic       last;
      logic       blank;
   } lpfs_scan_type;

endpackage

/* sv/led_panel_framebuffer_scan.sv */
// Channel   Dir  tdata (low bit up)                                  tuser / tlast
// req_      in   pix_x[6:0] pix_y[12:7] pixel_on[13]                  kind / -
// rsp_      out  top_rgb[2:0] bottom_rgb[5:3] row_addr[7:6] blank[8]  chain_sel / row_end
// csr_      in   APB, chain0_color at 0x0, chain1_color at 0x4
//
// One item is taken per cycle outside the clearing pass and stalls. A pixel
// write finishes in the cycle after it is taken (one bit-masked write to the
// frame store). A shift tick passes the input register, then the registered
// two-port store read, which is also the result register.
// After reset a clearing pass writes zeros over the store, one byte a cycle,
// all 64*PANELS_PER_CHAIN bytes (640 by default); req_tready stays low meanwhile.
// A stalled result holds req_ only when the next waiting item is a shift tick.
module led_panel_framebuffer_scan
   import lpfs_pkg::*;
#(
   parameter int PANELS_PER_CHAIN = DEF_PANELS_PER_CHAIN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // pix_x[6:0], pix_y[12:7], pixel_on[13], zero fill
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // top_rgb[2:0], bottom_rgb[5:3], row_addr[7:6], blank[8]
   output logic        rsp_tuser,   // chain_sel
   output logic        rsp_tlast,   // row_end
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int STORE_DEPTH = 2 * PANELS_PER_CHAIN * BYTES_PER_PANEL;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   logic [2:0]        color0_ff, color1_ff;
   logic              csr_index;
   logic              csr_write;

   logic              a_valid_ff, a_valid_in;
   logic              a_kind_ff;
   logic [6:0]        a_x_ff;
   logic [5:0]        a_y_ff;
   logic              a_on_ff;
   logic              a_go;
   logic              b_free;
   logic              shift_issue;
   logic              write_issue;

   logic              b_valid_ff, b_valid_in;
   lpfs_scan_type     b_info_ff;
   logic [2:0]        b_color_ff;

   lpfs_wr_type       wr;
   logic [ADDR_W-1:0] wr_addr;
   lpfs_scan_type     scan_info;
   logic [ADDR_W-1:0] rd_top_addr, rd_bot_addr;
   logic [7:0]        rd_top_data, rd_bot_data;
   logic              busy;
   logic [2:0]        top_rgb, bottom_rgb;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[2];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         color0_ff <= CHAIN0_COLOR_RESET;
         color1_ff <= CHAIN1_COLOR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_CHAIN0: color0_ff <= csr_pwdata[2:0];
            REG_CHAIN1: color1_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CHAIN0: csr_prdata = {29'd0, color0_ff};
         default:    csr_prdata = {29'd0, color1_ff};
      endcase
   end

   // input stage
   assign b_free = !b_valid_ff || rsp_tready;
   assign a_go = a_valid_ff && ((a_kind_ff == KIND_WRITE) || b_free);
   assign write_issue = a_valid_ff && (a_kind_ff == KIND_WRITE);
   assign shift_issue = a_valid_ff && (a_kind_ff == KIND_SHIFT) && b_free;
   assign req_tready = !busy && (!a_valid_ff || a_go);

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_tvalid && req_tready) begin
         a_valid_in = 1'b1;
      end else if (a_go) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         a_kind_ff <= req_tuser;
         a_x_ff <= req_tdata[6:0];
         a_y_ff <= req_tdata[12:7];
         a_on_ff <= req_tdata[13];
      end
   end

   lpfs_pixel_map #(
      .PANELS_PER_CHAIN(PANELS_PER_CHAIN)
   ) u_pixel_map (
      .enable   (write_issue),
      .pix_x    (a_x_ff),
      .pix_y    (a_y_ff),
      .pixel_on (a_on_ff),
      .wr       (wr),
      .wr_addr  (wr_addr)
   );

   lpfs_scan #(
      .PANELS_PER_CHAIN(PANELS_PER_CHAIN)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .advance     (shift_issue),
      .info        (scan_info),
      .rd_top_addr (rd_top_addr),
      .rd_bot_addr (rd_bot_addr)
   );

   lpfs_store #(
      .PANELS_PER_CHAIN(PANELS_PER_CHAIN)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr          (wr),
      .wr_addr     (wr_addr),
      .rd_en       (shift_issue),
      .rd_top_addr (rd_top_addr),
      .rd_bot_addr (rd_bot_addr),
      .rd_top_data (rd_top_data),
      .rd_bot_data (rd_bot_data),
      .busy        (busy)
   );

   // result stage: the store read data register holds while stalled
   always_comb begin
      b_valid_in = b_valid_ff;
      if (shift_issue) begin
         b_valid_in = 1'b1;
      end else if (rsp_tready) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_issue) begin
         b_info_ff <= scan_info;
         b_color_ff <= scan_info.chain ? color1_ff : color0_ff;
      end
   end

   assign top_rgb = rd_top_data[b_info_ff.bit_sel] ? b_color_ff : 3'd0;
   assign bottom_rgb = rd_bot_data[b_info_ff.bit_sel] ? b_color_ff : 3'd0;

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tuser = b_info_ff.chain;
   assign rsp_tlast = b_info_ff.last;
   assign rsp_tdata = {7'd0, b_info_ff.blank, b_info_ff.row, bottom_rgb, top_rgb};

`ifndef SYNTHESIS
   a_no_accept_while_clearing : assert property (
      @(posedge clock) disable iff (reset) busy |-> !req_tready)
      else $error("item accepted during store clearing pass");

   a_no_write_while_clearing : assert property (
      @(posedge clock) disable iff (reset) busy |-> !a_valid_ff)
      else $error("item in input stage during store clearing pass");

   a_row_end_on_chain_one : assert property (
      @(posedge clock) disable iff (reset) (rsp_tvalid && rsp_tlast) |-> rsp_tuser)
      else $error("row end flagged on chain zero");

   a_blank_on_row_zero : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[8]) |-> (rsp_tdata[7:6] == 2'd0))
      else $error("blank outside row zero");

   a_shift_needs_room : assert property (
      @(posedge clock) disable iff (reset)
      shift_issue |-> (!b_valid_ff || rsp_tready))
      else $error("shift read overwrites a pending result");
`endif

endmodule

/* sv/lpfs_pixel_map.sv */
module lpfs_pixel_map
   import lpfs_pkg::*;
#(
   parameter int PANELS_PER_CHAIN = DEF_PANELS_PER_CHAIN,
   localparam int ADDR_W = $clog2(2 * PANELS_PER_CHAIN * BYTES_PER_PANEL)
) (
   input  logic                  enable,
   input  logic [6:0]            pix_x,
   input  logic [5:0]            pix_y,
   input  logic                  pixel_on,
   output lpfs_wr_type           wr,
   output logic [ADDR_W-1:0]     wr_addr
);

   localparam int STORE_PANELS = 2 * PANELS_PER_CHAIN;

   logic [2:0] panel_col;
   logic [4:0] panel;
   logic [6:0] x_mirror;
   logic [6:0] x_local;
   logic [3:0] lx;
   logic [3:0] ly;
   logic [4:0] byte_ix;
   logic       in_range;

   assign panel_col = pix_x[6:4];
   assign x_mirror = 7'(MAX_X) - pix_x;
   assign ly = pix_y[3:0];

   // serpentine: bands 0 and 3 run right to left
   always_comb begin
      case (pix_y[5:4])
         2'd0: begin
            panel = 5'd4 - {2'b00, panel_col};
            x_local = x_mirror;
         end
         2'd1: begin
            panel = {2'b00, panel_col} + 5'd5;
            x_local = pix_x;
         end
         2'd2: begin
            panel = {2'b00, panel_col} + 5'd15;
            x_local = pix_x;
         end
         default: begin
            panel = 5'd14 - {2'b00, panel_col};
            x_local = x_mirror;
         end
      endcase
   end

   assign lx = x_local[3:0];
   // half, row within quad, column half, upper/lower nibble row
   assign byte_ix = {ly[3], ly[1:0], lx[3], ly[2]};

   assign in_range = (pix_x <= 7'(MAX_X)) && ({1'b0, panel} < 6'(STORE_PANELS));

   assign wr.en = enable && in_range;
   assign wr.bit_sel = ly[2] ? lx[2:0] : ~lx[2:0];
   assign wr.value = pixel_on;
   assign wr_addr = ADDR_W'({panel, byte_ix});

endmodule

/* sv/lpfs_scan.sv */
module lpfs_scan
   import lpfs_pkg::*;
#(
   parameter int PANELS_PER_CHAIN = DEF_PANELS_PER_CHAIN,
   localparam int ADDR_W = $clog2(2 * PANELS_PER_CHAIN * BYTES_PER_PANEL)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   output lpfs_scan_type         info,
   output logic [ADDR_W-1:0]     rd_top_addr,
   output logic [ADDR_W-1:0]     rd_bot_addr
);

   localparam logic [3:0] LAST_PANEL = 4'(PANELS_PER_CHAIN - 1);
   localparam logic [4:0] COL_LAST = 5'd31;

   logic [1:0] row_ff, row_in;
   logic [3:0] panel_ff, panel_in;
   logic [4:0] column_ff, column_in;
   logic       chain_ff, chain_in;
   logic [4:0] rd_panel;
   logic [3:0] byte_ix;

   always_comb begin
      row_in = row_ff;
      panel_in = panel_ff;
      column_in = column_ff;
      chain_in = chain_ff;
      if (advance) begin
         if (!chain_ff) begin
            chain_in = 1'b1;
         end else begin
            chain_in = 1'b0;
            if (column_ff != COL_LAST) begin
               column_in = column_ff + 5'd1;
            end else begin
               column_in = '0;
               if ({1'b0, panel_ff} + 5'd1 < 5'(PANELS_PER_CHAIN)) begin
                  panel_in = panel_ff + 4'd1;
               end else begin
                  panel_in = '0;
                  row_in = row_ff + 2'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         panel_ff <= '0;
         column_ff <= '0;
         chain_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         panel_ff <= panel_in;
         column_ff <= column_in;
         chain_ff <= chain_in;
      end
   end

   // chain one panels sit after the chain zero panels
   assign rd_panel = {1'b0, panel_ff} + (chain_ff ? 5'(PANELS_PER_CHAIN) : 5'd0);
   assign byte_ix = {row_ff, column_ff[4:3]};
   assign rd_top_addr = ADDR_W'({rd_panel, 1'b0, byte_ix});
   assign rd_bot_addr = ADDR_W'({rd_panel, 1'b1, byte_ix});

   assign info.chain = chain_ff;
   assign info.bit_sel = column_ff[2:0];
   assign info.row = row_ff;
   assign info.last = chain_ff && (column_ff == COL_LAST) && (panel_ff >= LAST_PANEL);
   assign info.blank = (row_ff == 2'd0);

endmodule

/* sv/lpfs_store.sv */
module lpfs_store
   import lpfs_pkg::*;
#(
   parameter int PANELS_PER_CHAIN = DEF_PANELS_PER_CHAIN,
   localparam int ADDR_W = $clog2(2 * PANELS_PER_CHAIN * BYTES_PER_PANEL)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lpfs_wr_type           wr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_top_addr,
   input  logic [ADDR_W-1:0]     rd_bot_addr,
   output logic [7:0]            rd_top_data,
   output logic [7:0]            rd_bot_data,
   output logic                  busy
);

   localparam int STORE_DEPTH = 2 * PANELS_PER_CHAIN * BYTES_PER_PANEL;
   localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);

   logic [7:0]        store_ff [STORE_DEPTH];
   logic [7:0]        rd_top_ff;
   logic [7:0]        rd_bot_ff;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              busy_ff, busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         if (clr_addr_ff == CLR_LAST) begin
            busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // sweep zeros after reset, then masked bit writes
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         store_ff[clr_addr_ff] <= '0;
      end else if (wr.en) begin
         store_ff[wr_addr][wr.bit_sel] <= wr.value;
      end
      if (rd_en) begin
         rd_top_ff <= store_ff[rd_top_addr];
         rd_bot_ff <= store_ff[rd_bot_addr];
      end
   end

   assign rd_top_data = rd_top_ff;
   assign rd_bot_data = rd_bot_ff;
   assign busy = busy_ff;

endmodule
